// ===== sv/rde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible deque engine package
// Shared constants, codes, command and status types, and helper functions.
// ----------------------------------------------------------------------------
package rde_pkg;

  localparam int DEPTH      = 64;
  localparam int VALUE_BITS = 16;
  localparam int ELEM_W     = 16;
  localparam int ADDR_W     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = CNT_W + 1;

  typedef enum logic [1:0] {
    KIND_LOAD    = 2'd0,
    KIND_REVERSE = 2'd1,
    KIND_DELETE  = 2'd2,
    KIND_FINISH  = 2'd3
  } kind_e;

  typedef enum logic [1:0] {
    ST_ELEMENT  = 2'd0,
    ST_EMPTY    = 2'd1,
    ST_ERROR    = 2'd2,
    ST_OVERFLOW = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE   = 2'd0,
    S_SINGLE = 2'd1,
    S_EMIT   = 2'd2
  } state_e;

  typedef enum logic [2:0] {
    OP_NONE       = 3'd0,
    OP_LOAD       = 3'd1,
    OP_REVERSE    = 3'd2,
    OP_DELETE     = 3'd3,
    OP_START_EMIT = 3'd4,
    OP_EMIT       = 3'd5,
    OP_SINGLE_OUT = 3'd6,
    OP_CLEAR      = 3'd7
  } op_e;

  typedef struct packed {
    op_e op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic error_seen;
    logic overflow_seen;
    logic empty;
    logic out_free;
    logic emit_done;
  } dp_stat_t;

  // Reduces a sum of two values below DEPTH back into the slot range.
  function automatic logic [ADDR_W-1:0] wrap_slot(input logic [SUM_W-1:0] sum);
    logic [SUM_W-1:0] red;
    red = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
    return red[ADDR_W-1:0];
  endfunction

  function automatic logic [VALUE_BITS-1:0] to_store(input logic [ELEM_W-1:0] val);
    logic [31:0] wide;
    wide = 32'(val);
    return wide[VALUE_BITS-1:0];
  endfunction

  function automatic logic [ELEM_W-1:0] to_elem(input logic [VALUE_BITS-1:0] val);
    logic [31:0] wide;
    wide = 32'(val);
    return wide[ELEM_W-1:0];
  endfunction

endpackage
`default_nettype wire

// ===== sv/rde_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds its
// data while no read is issued.
// ----------------------------------------------------------------------------
module rde_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               we_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]                   wdata_i,
  input  wire logic                               re_i,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic      [WIDTH-1:0]                   rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ===== sv/rde_ctrl.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible deque controller
// Decodes input commands and sequences the finish runs of the datapath.
// ----------------------------------------------------------------------------
module rde_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire rde_pkg::kind_e   kind_i,
  input  wire rde_pkg::dp_stat_t stat_i,
  output rde_pkg::ctrl_cmd_t    cmd_o
);
  import rde_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o.op   = OP_NONE;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          case (kind_i)
            KIND_LOAD:    cmd_o.op = OP_LOAD;
            KIND_REVERSE: cmd_o.op = OP_REVERSE;
            KIND_DELETE:  cmd_o.op = OP_DELETE;
            KIND_FINISH: begin
              if (stat_i.error_seen || stat_i.overflow_seen || stat_i.empty) begin
                state_d = S_SINGLE;
              end else begin
                cmd_o.op = OP_START_EMIT;
                state_d  = S_EMIT;
              end
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_SINGLE: begin
        if (stat_i.out_free) begin
          cmd_o.op = OP_SINGLE_OUT;
          state_d  = S_IDLE;
        end
      end
      S_EMIT: begin
        if (stat_i.emit_done) begin
          cmd_o.op = OP_CLEAR;
          state_d  = S_IDLE;
        end else begin
          cmd_o.op = OP_EMIT;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  ast_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> (state_q == S_IDLE))
    else $error("input ready outside idle");

  ast_emit_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_o.op == OP_START_EMIT) |=> (state_q == S_EMIT))
    else $error("emit run did not start");

  ast_single_exit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SINGLE && stat_i.out_free) |=> (state_q == S_IDLE))
    else $error("single result state did not end");

endmodule
`default_nettype wire

// ===== sv/rde_dp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible deque datapath
// Ring pointers, status flags, the element store and the output register.
// ----------------------------------------------------------------------------
module rde_dp (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire rde_pkg::ctrl_cmd_t         cmd_i,
  input  wire logic [rde_pkg::ELEM_W-1:0] value_i,
  output rde_pkg::dp_stat_t               stat_o,
  output logic                            out_valid_o,
  input  wire logic                       out_ready_i,
  output rde_pkg::status_e                out_status_o,
  output logic [rde_pkg::ELEM_W-1:0]      out_element_o,
  output logic                            out_last_o
);
  import rde_pkg::*;

  localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [CNT_W-1:0]  ONE_CNT   = CNT_W'(1);

  logic [ADDR_W-1:0] head_q, head_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic              rev_q, rev_d;
  logic              err_q, err_d;
  logic              ovf_q, ovf_d;
  logic [ADDR_W-1:0] ptr_q, ptr_d;
  logic [CNT_W-1:0]  left_q, left_d;
  logic              pend_q, pend_d;
  logic              pend_last_q, pend_last_d;
  logic              oval_q, oval_d;
  status_e           ostat_q, ostat_d;
  logic [ELEM_W-1:0] oelem_q, oelem_d;
  logic              olast_q, olast_d;

  logic                  we;
  logic [ADDR_W-1:0]     waddr;
  logic                  re;
  logic [VALUE_BITS-1:0] rdata;
  logic                  out_free;
  logic                  consume;
  logic                  issue;
  logic [ADDR_W-1:0]     head_inc;
  logic [ADDR_W-1:0]     head_dec;
  logic [ADDR_W-1:0]     back_slot;
  logic [ADDR_W-1:0]     tail_slot;

  assign out_free  = !oval_q || out_ready_i;
  assign head_inc  = (head_q == LAST_SLOT) ? '0 : head_q + 1'b1;
  assign head_dec  = (head_q == '0) ? LAST_SLOT : head_q - 1'b1;
  assign back_slot = wrap_slot(SUM_W'(head_q) + SUM_W'(count_q));
  assign tail_slot = wrap_slot(SUM_W'(head_q) + SUM_W'(count_q - ONE_CNT));

  always_comb begin
    head_d      = head_q;
    count_d     = count_q;
    rev_d       = rev_q;
    err_d       = err_q;
    ovf_d       = ovf_q;
    ptr_d       = ptr_q;
    left_d      = left_q;
    pend_d      = pend_q;
    pend_last_d = pend_last_q;
    oval_d      = oval_q && !out_ready_i;
    ostat_d     = ostat_q;
    oelem_d     = oelem_q;
    olast_d     = olast_q;
    we          = 1'b0;
    waddr       = back_slot;
    re          = 1'b0;
    consume     = 1'b0;
    issue       = 1'b0;
    case (cmd_i.op)
      OP_LOAD: begin
        if (count_q == FULL_CNT) begin
          ovf_d = 1'b1;
        end else begin
          we      = 1'b1;
          count_d = count_q + ONE_CNT;
          if (rev_q) begin
            waddr  = head_dec;
            head_d = head_dec;
          end
        end
      end
      OP_REVERSE: rev_d = !rev_q;
      OP_DELETE: begin
        if (count_q == '0) begin
          err_d = 1'b1;
        end else begin
          count_d = count_q - ONE_CNT;
          if (count_q == ONE_CNT) begin
            head_d = '0;
          end else if (!rev_q) begin
            head_d = head_inc;
          end
        end
      end
      OP_START_EMIT: begin
        ptr_d  = rev_q ? tail_slot : head_q;
        left_d = count_q;
        pend_d = 1'b0;
      end
      OP_EMIT: begin
        consume = pend_q && out_free;
        issue   = (left_q != '0) && (!pend_q || consume);
        if (consume) begin
          oval_d  = 1'b1;
          ostat_d = ST_ELEMENT;
          oelem_d = to_elem(rdata);
          olast_d = pend_last_q;
        end
        if (issue) begin
          re          = 1'b1;
          left_d      = left_q - ONE_CNT;
          pend_last_d = (left_q == ONE_CNT);
          if (rev_q) begin
            ptr_d = (ptr_q == '0) ? LAST_SLOT : ptr_q - 1'b1;
          end else begin
            ptr_d = (ptr_q == LAST_SLOT) ? '0 : ptr_q + 1'b1;
          end
        end
        pend_d = issue || (pend_q && !consume);
      end
      OP_SINGLE_OUT: begin
        oval_d  = 1'b1;
        oelem_d = '0;
        olast_d = 1'b1;
        if (err_q) begin
          ostat_d = ST_ERROR;
        end else if (ovf_q) begin
          ostat_d = ST_OVERFLOW;
        end else begin
          ostat_d = ST_EMPTY;
        end
        head_d  = '0;
        count_d = '0;
        rev_d   = 1'b0;
        err_d   = 1'b0;
        ovf_d   = 1'b0;
      end
      OP_CLEAR: begin
        head_d  = '0;
        count_d = '0;
        rev_d   = 1'b0;
        err_d   = 1'b0;
        ovf_d   = 1'b0;
      end
      default: begin
        head_d = head_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      rev_q   <= 1'b0;
      err_q   <= 1'b0;
      ovf_q   <= 1'b0;
      left_q  <= '0;
      pend_q  <= 1'b0;
      oval_q  <= 1'b0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
      rev_q   <= rev_d;
      err_q   <= err_d;
      ovf_q   <= ovf_d;
      left_q  <= left_d;
      pend_q  <= pend_d;
      oval_q  <= oval_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    pend_last_q <= pend_last_d;
    ostat_q     <= ostat_d;
    oelem_q     <= oelem_d;
    olast_q     <= olast_d;
  end

  rde_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (to_store(value_i)),
    .re_i    (re),
    .raddr_i (ptr_q),
    .rdata_o (rdata)
  );

  assign stat_o.error_seen    = err_q;
  assign stat_o.overflow_seen = ovf_q;
  assign stat_o.empty         = (count_q == '0);
  assign stat_o.out_free      = out_free;
  assign stat_o.emit_done     = (left_q == '0) && !pend_q;

  assign out_valid_o   = oval_q;
  assign out_status_o  = ostat_q;
  assign out_element_o = oelem_q;
  assign out_last_o    = olast_q;

  ast_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= FULL_CNT)
    else $error("element count beyond capacity");

  ast_head_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q == '0) |-> (head_q == '0))
    else $error("head not at slot zero on an empty deque");

  ast_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_CLEAR || cmd_i.op == OP_SINGLE_OUT)
      |=> (count_q == '0 && !rev_q && !err_q && !ovf_q))
    else $error("deque not cleared after a finish");

  ast_emit_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.op == OP_START_EMIT) |=> (left_q == count_q && !pend_q))
    else $error("emit run loaded a wrong length");

endmodule
`default_nettype wire

// ===== sv/reversible_deque_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible deque engine
// Ring-buffer deque with a direction flag, driven by a stream of commands.
// ----------------------------------------------------------------------------
// Load, reverse and delete commands are each applied in the cycle they are
// taken. A finish command is accepted from idle and then streams the stored
// elements at one per cycle while the output is free, from the single read
// port of the element memory, whose read is registered, then clears the
// deque; a finish that reports an empty list, a delete error or an overflow
// moves its one result into the output register in the cycle after it is
// accepted, once that register is free. No new command is accepted until a
// finish run has moved its last result into the output register, and a
// stalled output stretches the run by the cycles of the stall.
module reversible_deque_engine (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [15:0] s_axis_tdata_i,   // [15:0] value
  input  wire logic [1:0]  s_axis_tuser_i,   // [1:0] kind
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [15:0] element
  output logic [1:0]       m_axis_tuser_o,   // [1:0] status
  output logic             m_axis_tlast_o
);
  import rde_pkg::*;

  ctrl_cmd_t cmd;
  dp_stat_t  stat;
  status_e   out_status;

  rde_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .kind_i     (kind_e'(s_axis_tuser_i)),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rde_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .value_i       (s_axis_tdata_i),
    .stat_o        (stat),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_status_o  (out_status),
    .out_element_o (m_axis_tdata_o),
    .out_last_o    (m_axis_tlast_o)
  );

  assign m_axis_tuser_o = out_status;

endmodule
`default_nettype wire

// ===== test/rde_result_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible deque engine result checker
// Watches the command and result streams and keeps its own copy of the deque.
// Every command transfer updates that copy, and a finish command queues the
// results it should produce. Every result transfer is compared field by field
// with the oldest queued result. The checker reports the mismatch count and the
// number of results still outstanding.
// ----------------------------------------------------------------------------
module rde_result_checker (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cmd_valid_i,
  input  wire logic              cmd_ready_i,
  input  wire logic [15:0]       cmd_data_i,
  input  wire logic [1:0]        cmd_user_i,
  input  wire logic              res_valid_i,
  input  wire logic              res_ready_i,
  input  wire logic [15:0]       res_data_i,
  input  wire logic [1:0]        res_user_i,
  input  wire logic              res_last_i,
  output int                     outstanding_o,
  output int                     mismatches_o
);
  import rde_pkg::*;

  typedef struct packed {
    status_e           status;
    logic [ELEM_W-1:0] element;
    logic              last;
  } deque_result_t;

  logic [VALUE_BITS-1:0] slots [DEPTH];
  logic [ADDR_W-1:0]     front_slot;
  logic [CNT_W-1:0]      live_count;
  logic                  rev_order;
  logic                  delete_err;
  logic                  load_ovf;
  deque_result_t         expected_q [$];
  int                    mismatches;

  function automatic logic [ADDR_W-1:0] slot_at(input int offset);
    return ADDR_W'((int'(front_slot) + offset) % DEPTH);
  endfunction

  task automatic clear_deque();
    front_slot = '0;
    live_count = '0;
    rev_order  = 1'b0;
    delete_err = 1'b0;
    load_ovf   = 1'b0;
  endtask

  task automatic queue_result(input status_e status, input logic [ELEM_W-1:0] element,
                              input logic last);
    deque_result_t res;
    res.status  = status;
    res.element = element;
    res.last    = last;
    expected_q.insert(expected_q.size(), res);
  endtask

  task automatic apply_command(input kind_e kind, input logic [15:0] value);
    int offset;
    case (kind)
      KIND_LOAD: begin
        if (int'(live_count) >= DEPTH) begin
          load_ovf = 1'b1;
        end else if (!rev_order) begin
          slots[slot_at(int'(live_count))] = value[VALUE_BITS-1:0];
          live_count = live_count + 1'b1;
        end else begin
          front_slot = slot_at(DEPTH - 1);
          slots[front_slot] = value[VALUE_BITS-1:0];
          live_count = live_count + 1'b1;
        end
      end
      KIND_REVERSE: begin
        rev_order = !rev_order;
      end
      KIND_DELETE: begin
        if (live_count == 0) begin
          delete_err = 1'b1;
        end else begin
          if (!rev_order) front_slot = slot_at(1);
          live_count = live_count - 1'b1;
          if (live_count == 0) front_slot = '0;
        end
      end
      default: begin
        if (delete_err) begin
          queue_result(ST_ERROR, '0, 1'b1);
        end else if (load_ovf) begin
          queue_result(ST_OVERFLOW, '0, 1'b1);
        end else if (live_count == 0) begin
          queue_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int i = 0; i < int'(live_count); i++) begin
            offset = rev_order ? (int'(live_count) - 1 - i) : i;
            queue_result(ST_ELEMENT, ELEM_W'(slots[slot_at(offset)]),
                         (i + 1 == int'(live_count)));
          end
        end
        clear_deque();
      end
    endcase
  endtask

  task automatic check_result();
    deque_result_t want;
    if (expected_q.size() == 0) begin
      $error("result with no expectation: status %0d element %h last %0d",
             res_user_i, res_data_i, res_last_i);
      mismatches++;
    end else begin
      want = expected_q[0];
      expected_q.delete(0);
      if (want.status != status_e'(res_user_i)) begin
        $error("status mismatch: expected %0d, actual %0d", want.status, res_user_i);
        mismatches++;
      end
      if (want.element != res_data_i) begin
        $error("element mismatch: expected %h, actual %h", want.element, res_data_i);
        mismatches++;
      end
      if (want.last != res_last_i) begin
        $error("last mismatch: expected %0d, actual %0d", want.last, res_last_i);
        mismatches++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clear_deque();
      expected_q.delete();
      mismatches = 0;
      outstanding_o <= 0;
      mismatches_o  <= 0;
    end else begin
      if (res_valid_i && res_ready_i) check_result();
      if (cmd_valid_i && cmd_ready_i) apply_command(kind_e'(cmd_user_i), cmd_data_i);
      outstanding_o <= expected_q.size();
      mismatches_o  <= mismatches;
    end
  end

endmodule
`default_nettype wire

// ===== test/tb_reversible_deque_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// Reversible deque engine testbench
// Drives command streams into the deque engine and lets a checker compare
// every result transfer against its own prediction. A short directed part
// covers the empty, error and reversed cases, a filled deque is emitted
// while the result side holds off, another is loaded past its capacity,
// and random command runs follow under several patterns of sender idling
// and receiver stalling.
// ----------------------------------------------------------------------------
module tb_reversible_deque_engine;
  import rde_pkg::*;

  localparam int IDLE_LIMIT   = 2000;
  localparam int HOLD_CYCLES  = 300;
  localparam int HOLD_LOADS   = 16;
  localparam int PHASE_ITEMS  = 10;
  localparam int DRAIN_CYCLES = 20;

  logic        clk_i     = 1'b0;
  logic        rst_ni    = 1'b0;
  logic        cmd_valid = 1'b0;
  logic [15:0] cmd_value = '0;
  kind_e       cmd_kind  = KIND_LOAD;
  logic        res_ready = 1'b0;

  wire logic        cmd_ready;
  wire logic        res_valid;
  wire logic [15:0] res_element;
  wire logic [1:0]  res_status;
  wire logic        res_last;

  int outstanding;
  int mismatches;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int hold_request   = 0;
  int commands_sent  = 0;
  int quiet_cycles   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  reversible_deque_engine u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (cmd_valid),
    .s_axis_tready_o (cmd_ready),
    .s_axis_tdata_i  (cmd_value),
    .s_axis_tuser_i  (cmd_kind),
    .m_axis_tvalid_o (res_valid),
    .m_axis_tready_i (res_ready),
    .m_axis_tdata_o  (res_element),
    .m_axis_tuser_o  (res_status),
    .m_axis_tlast_o  (res_last)
  );

  rde_result_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_valid_i   (cmd_valid),
    .cmd_ready_i   (cmd_ready),
    .cmd_data_i    (cmd_value),
    .cmd_user_i    (cmd_kind),
    .res_valid_i   (res_valid),
    .res_ready_i   (res_ready),
    .res_data_i    (res_element),
    .res_user_i    (res_status),
    .res_last_i    (res_last),
    .outstanding_o (outstanding),
    .mismatches_o  (mismatches)
  );

  function automatic logic [15:0] random_value();
    int pick;
    pick = $urandom_range(7);
    if (pick == 0) return 16'h0000;
    if (pick == 1) return 16'hFFFF;
    return 16'($urandom);
  endfunction

  task automatic send_command(input kind_e kind, input logic [15:0] value);
    while ($urandom_range(99) < send_idle_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk_i);
    end
    cmd_valid <= 1'b1;
    cmd_kind  <= kind;
    cmd_value <= value;
    @(posedge clk_i);
    while (!cmd_ready) @(posedge clk_i);
    commands_sent++;
  endtask

  task automatic wait_drained();
    cmd_valid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  task automatic fill_deque(input int loads, input int reverse_pct);
    int done;
    done = 0;
    while (done < loads) begin
      if ($urandom_range(99) < reverse_pct) begin
        send_command(KIND_REVERSE, random_value());
      end else begin
        send_command(KIND_LOAD, random_value());
        done++;
      end
    end
  endtask

  task automatic send_run(input int max_len);
    int len;
    int pick;
    len = $urandom_range(max_len, 0);
    repeat (len) begin
      pick = $urandom_range(9);
      if (pick < 5) send_command(KIND_LOAD, random_value());
      else if (pick < 7) send_command(KIND_REVERSE, random_value());
      else send_command(KIND_DELETE, random_value());
    end
    send_command(KIND_FINISH, random_value());
  endtask

  task automatic run_phase(input int idle_pct, input int stall_pct, input int items);
    int target;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = commands_sent + items;
    while (commands_sent < target) begin
      if ($urandom_range(9) == 0) send_command(kind_e'($urandom_range(3)), random_value());
      else send_run(10);
    end
    wait_drained();
  endtask

  initial begin : receiver
    int left;
    forever begin
      @(posedge clk_i);
      if (hold_request > 0) begin
        left = hold_request;
        hold_request = 0;
        res_ready <= 1'b0;
        while (left > 0) begin
          @(posedge clk_i);
          left--;
        end
      end else begin
        res_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if ((cmd_valid && cmd_ready) || (res_valid && res_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin : stimulus
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_command(KIND_FINISH, 16'h0000);
    send_command(KIND_DELETE, 16'hFFFF);
    send_command(KIND_FINISH, 16'h0000);
    send_command(KIND_LOAD, 16'h0000);
    send_command(KIND_LOAD, 16'hFFFF);
    send_command(KIND_LOAD, 16'hA5A5);
    send_command(KIND_FINISH, 16'hFFFF);
    send_command(KIND_LOAD, 16'h0001);
    send_command(KIND_LOAD, 16'h0002);
    send_command(KIND_REVERSE, 16'h0000);
    send_command(KIND_LOAD, 16'h0003);
    send_command(KIND_FINISH, 16'h0000);
    send_command(KIND_LOAD, 16'h8000);
    send_command(KIND_LOAD, 16'h5A5A);
    send_command(KIND_REVERSE, 16'h0000);
    send_command(KIND_DELETE, 16'h0000);
    send_command(KIND_REVERSE, 16'h0000);
    send_command(KIND_FINISH, 16'h0000);
    send_command(KIND_REVERSE, 16'h0000);
    send_command(KIND_REVERSE, 16'h0000);
    send_command(KIND_LOAD, 16'h7FFF);
    send_command(KIND_DELETE, 16'h0000);
    send_command(KIND_FINISH, 16'h0000);
    wait_drained();

    // The result side holds off while a filled deque is emitted, so the engine
    // stalls its command side with the next run already offered.
    hold_request = HOLD_CYCLES;
    fill_deque(HOLD_LOADS, 20);
    send_command(KIND_FINISH, random_value());
    send_run(6);
    wait_drained();

    fill_deque(DEPTH + 1, 0);
    send_command(KIND_FINISH, random_value());
    wait_drained();

    run_phase(0, 0, PHASE_ITEMS);
    run_phase(70, 0, PHASE_ITEMS);
    run_phase(0, 70, PHASE_ITEMS);
    run_phase(11, 11, PHASE_ITEMS);

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0 && outstanding == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
`default_nettype wire

// ===== filelist.f =====
sv/rde_pkg.sv
sv/rde_ram.sv
sv/rde_ctrl.sv
sv/rde_dp.sv
sv/reversible_deque_engine.sv
test/rde_result_checker.sv
test/tb_reversible_deque_engine.sv
